[hw/rtl/mi4_pkg.sv]
// Shared types and constants of the 4x4 matrix inverse block.
package mi4_pkg;

	localparam logic [3:0] LAST_POS = 4'd15;
	localparam logic [3:0] LAST_OP_MINOR = 4'd8;
	localparam logic [3:0] OP_DET_ACC = 4'd9;
	localparam logic [1:0] LAST_DET_TERM = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_X,
		ST_RD_M,
		ST_LAT,
		ST_MUL,
		ST_ACC,
		ST_DET_FIN,
		ST_OUT_START,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic {
		SRC_T,
		SRC_M
	} src_t;

	typedef enum logic [1:0] {
		DST_T,
		DST_M,
		DST_D
	} dst_t;

	typedef enum logic [1:0] {
		ACC_SET,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef struct packed {
		logic [3:0] rd_addr;
		logic       ld_x_elem;
		logic       ld_x_acc;
		src_t       x_src;
		logic       ld_mq;
		logic       mul_step;
		logic       acc_en;
		dst_t       acc_dst;
		acc_mode_t  acc_mode;
		logic       det_fin;
		logic       div_init;
		logic       div_flip;
		logic       div_step;
		logic       emit;
		logic [3:0] emit_pos;
	} mi4_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic singular;
	} mi4_status_t;

endpackage

[hw/rtl/matrix_inverse_4x4_top.sv]
// Top level of the 4x4 fixed-point matrix inverse by the adjugate.
//
// Channel   Direction  Handshake                      Fields
// load      in         start high and busy low        element_value, element_position,
//                                                     last_element
// result    out        result_valid, one cycle each   inverse_value, result_position,
//                                                     determinant_value, singular,
//                                                     saturated, last_result
//
// A load transaction that is not marked last writes one element into the store; busy stays
// low. A transaction marked last stores its element and then runs the whole inversion, with
// busy high until the sixteenth result has been issued. Every multiply op runs on the shared
// bit-serial multiplier, and every division on the restoring divider. A singular matrix ends
// after the determinant with sixteen results issued and no divisions.
// Reset clears the sequencer and the result strobe; the element store holds no reset value and
// every position must be written before the first inversion. Results cannot be held off.
module matrix_inverse_4x4_top
	import mi4_pkg::*;
#(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ELEM_WIDTH-1:0] element_value,
	input  logic [3:0]            element_position,
	input  logic                  last_element,
	output logic                  result_valid,
	output logic [ELEM_WIDTH-1:0] inverse_value,
	output logic [3:0]            result_position,
	output logic [ELEM_WIDTH-1:0] determinant_value,
	output logic                  singular,
	output logic                  saturated,
	output logic                  last_result
);

	mi4_cmd_t    cmd;
	mi4_status_t status;
	logic        accept;

	// A load transaction is taken whenever the sequencer is idle.
	assign accept = start && !busy;

	mi4_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept && last_element),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mi4_datapath #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (accept),
		.wr_addr           (element_position),
		.wr_data           (element_value),
		.cmd               (cmd),
		.status            (status),
		.result_valid      (result_valid),
		.inverse_value     (inverse_value),
		.result_position   (result_position),
		.determinant_value (determinant_value),
		.singular          (singular),
		.saturated         (saturated),
		.last_result       (last_result)
	);

endmodule

[hw/rtl/mi4_datapath.sv]
// Datapath of the 4x4 matrix inverse: element store, serial multiplier, accumulators, divider.
module mi4_datapath
	import mi4_pkg::*;
#(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [3:0]            wr_addr,
	input  logic [ELEM_WIDTH-1:0] wr_data,
	input  mi4_cmd_t              cmd,
	output mi4_status_t           status,
	output logic                  result_valid,
	output logic [ELEM_WIDTH-1:0] inverse_value,
	output logic [3:0]            result_position,
	output logic [ELEM_WIDTH-1:0] determinant_value,
	output logic                  singular,
	output logic                  saturated,
	output logic                  last_result
);

	localparam int W    = ELEM_WIDTH;
	localparam int AW   = 4 * W + 2;
	localparam int MAGW = 3 * W;
	localparam int NW   = 3 * W + 2 * FRAC_BITS;
	localparam int RW   = AW + 1;
	localparam int CW   = $clog2(NW);
	localparam logic [AW-1:0] D_HALF = {{(AW-1){1'b0}}, 1'b1} << (W - 1);
	localparam logic [NW-1:0] Q_HALF = {{(NW-1){1'b0}}, 1'b1} << (W - 1);
	localparam logic [W-1:0]  V_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  V_MIN  = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]  store_q [16];
	logic [W-1:0]  rd_q;
	logic [AW-1:0] x_q, p_q, t_q, m_q, d_q;
	logic [W-1:0]  mq_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] dmag_q;
	logic          dneg_q, sing_q, detclip_q, qneg_q;
	logic [W-1:0]  detv_q;
	logic [NW-1:0] nq_q;
	logic [RW-1:0] rem_q;

	logic [AW-1:0] mul_add, acc_old, acc_base, acc_term, acc_new;
	logic [AW-1:0] dmag_c, detmag_c, absm_c;
	logic          detclip_c;
	logic [W-1:0]  detv_c;
	logic [RW-1:0] trial_c;
	logic          ge_c;
	logic          qclip_c;
	logic [W-1:0]  qv_c;

	// Horner form of the signed product: the sign bit of the multiplier is weighted negative.
	always_comb begin
		if (!mq_q[W-1])
			mul_add = '0;
		else if (cnt_q == CW'(W - 1))
			mul_add = -x_q;
		else
			mul_add = x_q;
	end

	always_comb begin
		case (cmd.acc_dst)
			DST_T:   acc_old = t_q;
			DST_M:   acc_old = m_q;
			default: acc_old = d_q;
		endcase
		acc_base = (cmd.acc_mode == ACC_SET) ? '0 : acc_old;
		acc_term = (cmd.acc_mode == ACC_SUB) ? -p_q : p_q;
		acc_new  = acc_base + acc_term;
	end

	always_comb begin
		dmag_c   = d_q[AW-1] ? -d_q : d_q;
		detmag_c = dmag_c >> (3 * FRAC_BITS);
		if (d_q[AW-1]) begin
			detclip_c = detmag_c > D_HALF;
			detv_c    = detclip_c ? V_MIN : -detmag_c[W-1:0];
		end else begin
			detclip_c = detmag_c >= D_HALF;
			detv_c    = detclip_c ? V_MAX : detmag_c[W-1:0];
		end
	end

	always_comb begin
		absm_c  = m_q[AW-1] ? -m_q : m_q;
		trial_c = {rem_q[RW-2:0], nq_q[NW-1]};
		ge_c    = trial_c >= {1'b0, dmag_q};
		if (qneg_q) begin
			qclip_c = nq_q > Q_HALF;
			qv_c    = qclip_c ? V_MIN : -nq_q[W-1:0];
		end else begin
			qclip_c = nq_q >= Q_HALF;
			qv_c    = qclip_c ? V_MAX : nq_q[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[wr_addr] <= wr_data;
		rd_q <= store_q[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_x_elem)
			x_q <= {{(AW-W){rd_q[W-1]}}, rd_q};
		else if (cmd.ld_x_acc)
			x_q <= (cmd.x_src == SRC_T) ? t_q : m_q;

		if (cmd.ld_mq) begin
			mq_q  <= rd_q;
			p_q   <= '0;
			cnt_q <= CW'(W - 1);
		end else if (cmd.mul_step) begin
			p_q   <= (p_q << 1) + mul_add;
			mq_q  <= mq_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.div_init) begin
			cnt_q <= CW'(NW - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end

		if (cmd.acc_en) begin
			case (cmd.acc_dst)
				DST_T:   t_q <= acc_new;
				DST_M:   m_q <= acc_new;
				default: d_q <= acc_new;
			endcase
		end

		if (cmd.det_fin) begin
			dneg_q    <= d_q[AW-1];
			dmag_q    <= dmag_c;
			detv_q    <= detv_c;
			detclip_q <= detclip_c;
		end

		if (cmd.div_init) begin
			nq_q   <= {absm_c[MAGW-1:0], {(2 * FRAC_BITS){1'b0}}};
			rem_q  <= '0;
			qneg_q <= m_q[AW-1] ^ cmd.div_flip ^ dneg_q;
		end else if (cmd.div_step) begin
			rem_q <= ge_c ? (trial_c - {1'b0, dmag_q}) : trial_c;
			nq_q  <= {nq_q[NW-2:0], ge_c};
		end

		if (cmd.emit) begin
			inverse_value     <= sing_q ? '0 : qv_c;
			result_position   <= cmd.emit_pos;
			determinant_value <= detv_q;
			singular          <= sing_q;
			saturated         <= (!sing_q && qclip_c) || detclip_q;
			last_result       <= cmd.emit_pos == LAST_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			sing_q       <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cmd.det_fin)
				sing_q <= d_q == '0;
		end
	end

	assign status.cnt_zero = cnt_q == '0;
	assign status.singular = sing_q;

endmodule

[hw/rtl/mi4_ctrl.sv]
// Sequencer of the 4x4 matrix inverse: steps through cofactor products, determinant and divisions.
module mi4_ctrl
	import mi4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  mi4_status_t status,
	output mi4_cmd_t    cmd,
	output logic        busy
);

	ctl_state_t state_q, state_d;
	logic       out_phase_q;
	logic [3:0] k_q;
	logic [3:0] j_q;

	logic [1:0] sr, sc;
	logic [1:0] r0, r1, r2, c0, c1, c2;
	logic [3:0] addr_x, addr_m;
	logic       uses_elem;
	src_t       op_src;
	dst_t       op_dst;
	acc_mode_t  op_mode;

	// The minor drops row sr and column sc; the output phase takes the transposed cofactor.
	always_comb begin
		if (out_phase_q) begin
			sr = k_q[1:0];
			sc = k_q[3:2];
		end else begin
			sr = 2'd0;
			sc = k_q[1:0];
		end
		r0 = (sr == 2'd0) ? 2'd1 : 2'd0;
		r1 = (sr <= 2'd1) ? 2'd2 : 2'd1;
		r2 = (sr <= 2'd2) ? 2'd3 : 2'd2;
		c0 = (sc == 2'd0) ? 2'd1 : 2'd0;
		c1 = (sc <= 2'd1) ? 2'd2 : 2'd1;
		c2 = (sc <= 2'd2) ? 2'd3 : 2'd2;
	end

	always_comb begin
		addr_x    = '0;
		addr_m    = '0;
		uses_elem = 1'b1;
		op_src    = SRC_T;
		op_dst    = DST_T;
		op_mode   = ACC_SET;
		unique case (j_q)
			4'd0: begin addr_x = {r1, c1}; addr_m = {r2, c2}; end
			4'd1: begin addr_x = {r1, c2}; addr_m = {r2, c1}; op_mode = ACC_SUB; end
			4'd2: begin
				addr_m = {r0, c0}; uses_elem = 1'b0; op_dst = DST_M;
			end
			4'd3: begin addr_x = {r1, c0}; addr_m = {r2, c2}; end
			4'd4: begin addr_x = {r1, c2}; addr_m = {r2, c0}; op_mode = ACC_SUB; end
			4'd5: begin
				addr_m = {r0, c1}; uses_elem = 1'b0; op_dst = DST_M; op_mode = ACC_SUB;
			end
			4'd6: begin addr_x = {r1, c0}; addr_m = {r2, c1}; end
			4'd7: begin addr_x = {r1, c1}; addr_m = {r2, c0}; op_mode = ACC_SUB; end
			4'd8: begin
				addr_m = {r0, c2}; uses_elem = 1'b0; op_dst = DST_M; op_mode = ACC_ADD;
			end
			OP_DET_ACC: begin
				addr_m    = {2'd0, k_q[1:0]};
				uses_elem = 1'b0;
				op_src    = SRC_M;
				op_dst    = DST_D;
				if (k_q[1:0] == 2'd0)
					op_mode = ACC_SET;
				else if (k_q[0])
					op_mode = ACC_SUB;
				else
					op_mode = ACC_ADD;
			end
			default: begin end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (go) state_d = ST_RD_X;
			ST_RD_X:      state_d = ST_RD_M;
			ST_RD_M:      state_d = ST_LAT;
			ST_LAT:       state_d = ST_MUL;
			ST_MUL:       if (status.cnt_zero) state_d = ST_ACC;
			ST_ACC: begin
				if (out_phase_q)
					state_d = (j_q == LAST_OP_MINOR) ? ST_DIV_INIT : ST_RD_X;
				else if (j_q == OP_DET_ACC && k_q[1:0] == LAST_DET_TERM)
					state_d = ST_DET_FIN;
				else
					state_d = ST_RD_X;
			end
			ST_DET_FIN:   state_d = ST_OUT_START;
			ST_OUT_START: state_d = status.singular ? ST_EMIT : ST_RD_X;
			ST_DIV_INIT:  state_d = ST_DIV;
			ST_DIV:       if (status.cnt_zero) state_d = ST_EMIT;
			ST_EMIT:      state_d = (k_q == LAST_POS) ? ST_IDLE : ST_OUT_START;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.x_src    = op_src;
		cmd.acc_dst  = op_dst;
		cmd.acc_mode = op_mode;
		cmd.div_flip = k_q[2] ^ k_q[0];
		cmd.emit_pos = k_q;
		unique case (state_q)
			ST_RD_X:     cmd.rd_addr = addr_x;
			ST_RD_M: begin
				cmd.rd_addr   = addr_m;
				cmd.ld_x_elem = uses_elem;
			end
			ST_LAT: begin
				cmd.ld_mq    = 1'b1;
				cmd.ld_x_acc = !uses_elem;
			end
			ST_MUL:      cmd.mul_step = 1'b1;
			ST_ACC:      cmd.acc_en = 1'b1;
			ST_DET_FIN:  cmd.det_fin = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_EMIT:     cmd.emit = 1'b1;
			default: begin end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_phase_q <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						out_phase_q <= 1'b0;
						k_q         <= '0;
						j_q         <= '0;
					end
				end
				ST_ACC: begin
					if (!out_phase_q && j_q == OP_DET_ACC) begin
						j_q <= '0;
						k_q <= k_q + 1'b1;
					end else if (!(out_phase_q && j_q == LAST_OP_MINOR)) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DET_FIN: begin
					out_phase_q <= 1'b1;
					k_q         <= '0;
					j_q         <= '0;
				end
				ST_EMIT: begin
					k_q <= k_q + 1'b1;
					j_q <= '0;
				end
				default: begin end
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

[test/matrix_inverse_4x4_top_tb.sv]
// Self-checking testbench of the 4x4 fixed-point matrix inverse: loads, prediction and checks.
`timescale 1ns / 100ps

module matrix_inverse_4x4_top_tb;
	import mi4_pkg::*;

	// Wide signed value that holds every product, cofactor and shifted numerator exactly.
	typedef logic signed [255:0] wide_t;

	// One load transaction as the driver presents it.
	typedef struct {
		logic [31:0] value;
		logic [3:0]  pos;
		logic        last;
	} load_item_t;

	// One result transaction as the block should issue it.
	typedef struct {
		logic [31:0] inv;
		logic [3:0]  pos;
		logic [31:0] det;
		logic        sing;
		logic        sat;
		logic        last;
	} inv_result_t;

	localparam int TIMEOUT_CYCLES = 20000;
	localparam int DRAIN_CYCLES   = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] element_value = '0;
	logic [3:0]  element_position = '0;
	logic        last_element = 1'b0;
	logic        result_valid;
	logic [31:0] inverse_value;
	logic [3:0]  result_position;
	logic [31:0] determinant_value;
	logic        singular;
	logic        saturated;
	logic        last_result;

	// Pending loads, the predictor's own copy of the element store and the results still owed.
	load_item_t         load_q[$];
	logic signed [31:0] shadow_store [16];
	inv_result_t        owed_results[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  quiet_cycles = 0;
	bit  idle_now;

	matrix_inverse_4x4_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.element_value     (element_value),
		.element_position  (element_position),
		.last_element      (last_element),
		.result_valid      (result_valid),
		.inverse_value     (inverse_value),
		.result_position   (result_position),
		.determinant_value (determinant_value),
		.singular          (singular),
		.saturated         (saturated),
		.last_result       (last_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Determinant of the 3x3 minor that leaves out row sr and column sc, held at full width.
	function automatic wide_t minor_det(input int sr, input int sc);
		int    rs[3];
		int    cs[3];
		int    n;
		wide_t m[3][3];
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sr) begin rs[n] = i; n++; end
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sc) begin cs[n] = i; n++; end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = shadow_store[rs[i] * 4 + cs[j]];
		return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
			- m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
			+ m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
	endfunction

	// Clips a wide value into the 32-bit element range and flags whether it had to.
	function automatic logic [31:0] clip32(input wide_t a, output logic clipped);
		wide_t hi;
		wide_t lo;
		hi = 2147483647;
		lo = -hi - 1;
		clipped = 1'b1;
		if (a > hi) return 32'h7fff_ffff;
		if (a < lo) return 32'h8000_0000;
		clipped = 1'b0;
		return a[31:0];
	endfunction

	// Stores an accepted element and, when it closes a matrix, queues all sixteen inverse results.
	task automatic store_and_invert(input logic [31:0] value, input logic [3:0] pos,
			input logic last);
		wide_t       det;
		wide_t       scale;
		wide_t       cof;
		logic [31:0] det_q;
		logic        det_clip;
		logic        elem_clip;
		inv_result_t res;
		shadow_store[pos] = value;
		if (!last) return;
		det = 0;
		for (int k = 0; k < 4; k++) begin
			if (k % 2 == 1) det = det - wide_t'(shadow_store[k]) * minor_det(0, k);
			else            det = det + wide_t'(shadow_store[k]) * minor_det(0, k);
		end
		// The determinant carries four fraction fields; signed division truncates toward zero.
		scale = 1;
		scale = scale <<< 48;
		det_q = clip32(det / scale, det_clip);
		for (int k = 0; k < 16; k++) begin
			res.pos  = 4'(k);
			res.det  = det_q;
			res.sing = (det == 0);
			res.last = (k == 15);
			res.inv  = '0;
			elem_clip = 1'b0;
			if (det != 0) begin
				// Adjugate entry: cofactor of the transposed position with its chequerboard sign.
				cof = minor_det(k % 4, k / 4);
				if (((k / 4) + (k % 4)) % 2 == 1) cof = -cof;
				res.inv = clip32((cof <<< 32) / det, elem_clip);
			end
			res.sat = elem_clip || det_clip;
			owed_results.push_back(res);
		end
	endtask

	// A random element value, weighted toward small magnitudes so that many inverses fit.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 32'h3ffff)) - 32'h2_0000;
			6:                return $urandom;
			7: begin
				case ($urandom_range(0, 3))
					0:       return 32'h7fff_ffff;
					1:       return 32'h8000_0000;
					2:       return 32'hffff_ffff;
					default: return 32'h0;
				endcase
			end
			8:       return 32'($urandom_range(0, 255)) - 32'd128;
			default: return (32'($urandom_range(0, 8)) - 32'd4) << 16;
		endcase
	endfunction

	function automatic load_item_t mk_item(input logic [31:0] v, input int p, input bit l);
		load_item_t it;
		it.value = v;
		it.pos   = 4'(p);
		it.last  = l;
		return it;
	endfunction

	// Driver: a transaction completes on an edge where start is high and busy is low. An item
	// that meets busy is held unchanged until the block takes it; otherwise the next one is
	// presented at once, unless this cycle is picked as an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (start && !busy) begin
				store_and_invert(element_value, element_position, last_element);
				void'(load_q.pop_front());
			end
			if (!(start && busy)) begin
				// A long stretch in the middle of the run goes without any idle cycles.
				idle_now = (cycle_count < 100000 || cycle_count > 250000)
					&& ($urandom_range(0, 99) < 8);
				if (load_q.size() > 0 && !idle_now) begin
					start            <= 1'b1;
					element_value    <= load_q[0].value;
					element_position <= load_q[0].pos;
					last_element     <= load_q[0].last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is compared with the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at position %0d: inverse %h", result_position,
						inverse_value);
			end else begin
				if (inverse_value !== owed_results[0].inv
						|| result_position !== owed_results[0].pos
						|| determinant_value !== owed_results[0].det
						|| singular !== owed_results[0].sing
						|| saturated !== owed_results[0].sat
						|| last_result !== owed_results[0].last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected inv %h pos %0d det %h sing %b sat %b last %b,",
							owed_results[0].inv, owed_results[0].pos, owed_results[0].det,
							owed_results[0].sing, owed_results[0].sat, owed_results[0].last,
							" got inv %h pos %0d det %h sing %b sat %b last %b",
							inverse_value, result_position, determinant_value, singular,
							saturated, last_result);
				end
				void'(owed_results.pop_front());
			end
		end
	end

	// Watchdog: the longest correct silence includes the determinant phase, well under the limit.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= TIMEOUT_CYCLES) begin
				$display("** matrix_inverse_4x4_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int group;
		int row;
		// Directed part. The identity, in Q16.16, fills every position before the first inversion.
		for (int p = 0; p < 16; p++)
			load_q.push_back(mk_item((p % 5 == 0) ? 32'h0001_0000 : 32'h0, p, p == 15));
		// The most positive and most negative elements on the diagonal force clipped results.
		load_q.push_back(mk_item(32'h7fff_ffff, 0, 1'b0));
		load_q.push_back(mk_item(32'h8000_0000, 5, 1'b1));
		// A zeroed first row makes the matrix singular; position 3 is written twice.
		load_q.push_back(mk_item(32'hffff_ffff, 3, 1'b0));
		for (int p = 0; p < 4; p++)
			load_q.push_back(mk_item(32'h0, p, p == 3));
		// Random part: groups of writes closed by a last item, with singular rows now and then.
		while (load_q.size() < 480) begin
			group = $urandom_range(3, 16);
			for (int i = 0; i < group; i++)
				load_q.push_back(mk_item(pick_value(), $urandom_range(0, 15), 1'b0));
			if ($urandom_range(0, 7) == 0) begin
				row = $urandom_range(0, 3);
				for (int c = 0; c < 4; c++)
					load_q.push_back(mk_item(32'h0, row * 4 + c, 1'b0));
			end
			load_q.push_back(mk_item(pick_value(), $urandom_range(0, 15), 1'b1));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (load_q.size() == 0 && owed_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("** matrix_inverse_4x4_top: PASSED **");
		end else begin
			$display("** matrix_inverse_4x4_top: FAILED **");
		end
		$finish;
	end

endmodule
